FILE: rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, request and status codes and sizing for the sorted set engine.
// ----------------------------------------------------------------------------
package sse_pkg;

    // Number of keys the set can hold
    localparam int CAPACITY = 16;

    // Entry address width and entry count width (count reaches CAPACITY)
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef logic        [2:0]  req_t;
    typedef logic        [2:0]  status_t;
    typedef logic signed [31:0] key_t;

    // Request codes
    localparam req_t REQ_SEARCH    = 3'd0;
    localparam req_t REQ_INSERT    = 3'd1;
    localparam req_t REQ_REMOVE    = 3'd2;
    localparam req_t REQ_LIST_ASC  = 3'd3;
    localparam req_t REQ_LIST_DESC = 3'd4;

    // Status codes
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_NOT_FOUND = 3'd1;
    localparam status_t ST_PRESENT   = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;

endpackage

FILE: rtl/sorted_set_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_set_engine_core
// Keeps a set of distinct signed 32-bit keys in ascending order in a small
// single-port entry memory, and serves search, insert, remove and list requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time and is not ready until that request
// has produced all its results. Every memory access goes through one read
// port with registered data and one key comparator, so a search, insert or
// remove first scans the stored keys from the smallest up, reading each key
// passed before comparing it, and then decides. An insert then shifts the
// larger keys up and a remove shifts them down, a read and a write per moved
// key. A list request reads each key and then emits it, and an empty set
// answers a list with a single set-empty result. A result waits in the output
// register while the consumer stalls; request types 5 to 7 are taken and
// dropped without any result.
// ----------------------------------------------------------------------------
module sorted_set_engine_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sse_pkg::req_t    req_type,
    input  sse_pkg::key_t    key,
    output logic             out_valid,
    input  logic             out_ready,
    output sse_pkg::status_t status,
    output sse_pkg::key_t    value,
    output logic             is_last
);
    import sse_pkg::*;

    // Sequencer state codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_SHUP   = 4'd4;
    localparam logic [3:0] S_SUWR   = 4'd5;
    localparam logic [3:0] S_SHDN   = 4'd6;
    localparam logic [3:0] S_SDWR   = 4'd7;
    localparam logic [3:0] S_LRD    = 4'd8;
    localparam logic [3:0] S_LOUT   = 4'd9;

    // Entry memory and its registered read data
    key_t              entry_mem [CAPACITY];
    key_t              mem_rdata_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    key_t              mem_wdata;

    // Control and working registers
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              hit_reg, hit_next;
    req_t              req_reg, req_next;
    key_t              key_reg, key_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    key_t              value_reg, value_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              key_lt;
    logic              key_eq;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  desc_idx;

    // Shared comparator and index arithmetic
    assign key_lt   = mem_rdata_reg < key_reg;
    assign key_eq   = mem_rdata_reg == key_reg;
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign desc_idx = count_reg - CNT_W'(1) - idx_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign is_last   = last_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        mem_raddr      = idx_reg[ADDR_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[ADDR_W-1:0];
        mem_wdata      = mem_rdata_reg;

        // drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req_type;
                    key_next = key;
                    idx_next = '0;
                    case (req_type)
                        REQ_SEARCH, REQ_INSERT, REQ_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        REQ_LIST_ASC, REQ_LIST_DESC:
                        begin
                            state_next = (count_reg == '0) ? S_DECIDE : S_LRD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // walk up the stored keys until one is not less than the request key
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    pos_next   = idx_reg;
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    mem_raddr  = idx_reg[ADDR_W-1:0];
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (key_lt)
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN;
                end
                else
                begin
                    pos_next   = idx_reg;
                    hit_next   = key_eq;
                    state_next = S_DECIDE;
                end
            end

            // answer or start the shift, holding while the output is busy
            S_DECIDE:
            begin
                case (req_reg)
                    REQ_SEARCH:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = hit_reg ? ST_OK : ST_NOT_FOUND;
                            value_next     = key_reg;
                            last_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (hit_reg || count_reg == CNT_W'(CAPACITY))
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = hit_reg ? ST_PRESENT : ST_FULL;
                                value_next     = key_reg;
                                last_next      = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_SHUP;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_NOT_FOUND;
                                value_next     = key_reg;
                                last_next      = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next   = pos_reg;
                            state_next = S_SHDN;
                        end
                    end
                    default:
                    begin
                        // list of an empty set
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_EMPTY;
                            value_next     = '0;
                            last_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end

            // shift larger keys up one place, then drop the new key in
            S_SHUP:
            begin
                if (idx_reg == pos_reg)
                begin
                    if (out_free)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = pos_reg[ADDR_W-1:0];
                        mem_wdata      = key_reg;
                        count_next     = count_reg + CNT_W'(1);
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        value_next     = key_reg;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mem_raddr  = idx_dec[ADDR_W-1:0];
                    state_next = S_SUWR;
                end
            end

            S_SUWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = mem_rdata_reg;
                idx_next   = idx_dec;
                state_next = S_SHUP;
            end

            // shift larger keys down one place over the removed key
            S_SHDN:
            begin
                if (idx_inc >= count_reg)
                begin
                    if (out_free)
                    begin
                        count_next     = count_reg - CNT_W'(1);
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        value_next     = key_reg;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mem_raddr  = idx_inc[ADDR_W-1:0];
                    state_next = S_SDWR;
                end
            end

            S_SDWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = mem_rdata_reg;
                idx_next   = idx_inc;
                state_next = S_SHDN;
            end

            // fetch the next listed key
            S_LRD:
            begin
                mem_raddr  = (req_reg == REQ_LIST_ASC) ? idx_reg[ADDR_W-1:0]
                                                       : desc_idx[ADDR_W-1:0];
                state_next = S_LOUT;
            end

            S_LOUT:
            begin
                // hold the read address so the fetched key survives a stall
                mem_raddr = (req_reg == REQ_LIST_ASC) ? idx_reg[ADDR_W-1:0]
                                                      : desc_idx[ADDR_W-1:0];
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    value_next     = mem_rdata_reg;
                    last_next      = (idx_inc == count_reg);
                    idx_next       = idx_inc;
                    state_next     = (idx_inc == count_reg) ? S_IDLE : S_LRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        req_reg    <= req_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= entry_mem[mem_raddr];
    end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_set_engine_core. A directed table covers the
// empty set, extreme keys, duplicates, head, tail and middle removal, and the
// unused request codes. Phased random traffic follows: fill to capacity, drain,
// and mixed requests. Every result is checked against a local sorted-set
// predictor, with random idling on both sides and a long consumer stall.
// ----------------------------------------------------------------------------
module testbench;
    import sse_pkg::*;

    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   RANDOM_ITEMS  = 250;
    localparam int   IDLE_PERCENT  = 18;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   DRAIN_CYCLES  = 60;
    localparam key_t KEY_MIN       = 32'h8000_0000;
    localparam key_t KEY_MAX       = 32'h7fff_ffff;

    // Request codes the block takes and drops
    localparam req_t REQ_RESERVED_LO  = 3'd5;
    localparam req_t REQ_RESERVED_MID = 3'd6;
    localparam req_t REQ_RESERVED_HI  = 3'd7;

    typedef struct packed {
        status_t status;
        key_t    value;
        logic    is_last;
    } set_result_t;

    typedef struct packed {
        req_t    req;
        key_t    key;
        logic    typed;
        status_t status;
        key_t    value;
    } script_row_t;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} traffic_phase_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    req_t    req_type;
    key_t    key;
    logic    out_valid;
    logic    out_ready;
    status_t status;
    key_t    value;
    logic    is_last;

    // Predicted contents of the set
    key_t        set_keys [CAPACITY];
    int          set_count;
    set_result_t pending_results [$];

    int  mismatch_count;
    int  results_checked;
    int  requests_sent;
    int  ignored_sent;
    int  full_predicted;
    int  full_seen;
    int  present_seen;
    int  empty_seen;
    int  cycle_count;
    bit  calm;
    bit  hold_done;

    // Directed requests; typed rows carry the one result read off directly
    script_row_t script [0:21] = '{
        '{REQ_LIST_ASC,     32'sd0,   1'b1, ST_EMPTY,     32'sd0},
        '{REQ_LIST_DESC,    32'sd0,   1'b1, ST_EMPTY,     32'sd0},
        '{REQ_SEARCH,       32'sd0,   1'b1, ST_NOT_FOUND, 32'sd0},
        '{REQ_REMOVE,       32'sd5,   1'b1, ST_NOT_FOUND, 32'sd5},
        '{REQ_INSERT,       KEY_MAX,  1'b1, ST_OK,        KEY_MAX},
        '{REQ_INSERT,       KEY_MIN,  1'b1, ST_OK,        KEY_MIN},
        '{REQ_INSERT,       32'sd0,   1'b0, ST_OK,        32'sd0},
        '{REQ_INSERT,       -32'sd1,  1'b0, ST_OK,        32'sd0},
        '{REQ_INSERT,       KEY_MAX,  1'b1, ST_PRESENT,   KEY_MAX},
        '{REQ_SEARCH,       KEY_MIN,  1'b1, ST_OK,        KEY_MIN},
        '{REQ_SEARCH,       32'sd1,   1'b1, ST_NOT_FOUND, 32'sd1},
        '{REQ_RESERVED_LO,  -32'sd1,  1'b0, ST_OK,        32'sd0},
        '{REQ_RESERVED_MID, KEY_MIN,  1'b0, ST_OK,        32'sd0},
        '{REQ_RESERVED_HI,  32'h5a5a5a5a, 1'b0, ST_OK,    32'sd0},
        '{REQ_LIST_ASC,     32'sd9,   1'b0, ST_OK,        32'sd0},
        '{REQ_LIST_DESC,    -32'sd9,  1'b0, ST_OK,        32'sd0},
        '{REQ_REMOVE,       KEY_MAX,  1'b1, ST_OK,        KEY_MAX},
        '{REQ_REMOVE,       KEY_MIN,  1'b1, ST_OK,        KEY_MIN},
        '{REQ_REMOVE,       32'sd42,  1'b1, ST_NOT_FOUND, 32'sd42},
        '{REQ_INSERT,       32'sd7,   1'b0, ST_OK,        32'sd0},
        '{REQ_REMOVE,       32'sd0,   1'b0, ST_OK,        32'sd0},
        '{REQ_LIST_ASC,     32'sd0,   1'b0, ST_OK,        32'sd0}
    };

    sorted_set_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value     (value),
        .is_last   (is_last)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_result(input status_t st, input key_t v, input logic last);
        pending_results.push_back('{st, v, last});
    endtask

    // Apply one accepted request to the predicted set and queue its results
    task automatic apply_request(input req_t r, input key_t k);
        int pos;
        int i;
        bit hit;
        pos = 0;
        while (pos < set_count && set_keys[pos] < k)
            pos++;
        hit = (pos < set_count) && (set_keys[pos] == k);
        case (r)
            REQ_SEARCH:
                queue_result(hit ? ST_OK : ST_NOT_FOUND, k, 1'b1);
            REQ_INSERT:
                if (hit)
                    queue_result(ST_PRESENT, k, 1'b1);
                else if (set_count >= CAPACITY)
                begin
                    full_predicted++;
                    queue_result(ST_FULL, k, 1'b1);
                end
                else
                begin
                    for (i = set_count; i > pos; i--)
                        set_keys[i] = set_keys[i - 1];
                    set_keys[pos] = k;
                    set_count++;
                    queue_result(ST_OK, k, 1'b1);
                end
            REQ_REMOVE:
                if (!hit)
                    queue_result(ST_NOT_FOUND, k, 1'b1);
                else
                begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_keys[i] = set_keys[i + 1];
                    set_count--;
                    queue_result(ST_OK, k, 1'b1);
                end
            REQ_LIST_ASC, REQ_LIST_DESC:
                if (set_count == 0)
                    queue_result(ST_EMPTY, 32'sd0, 1'b1);
                else
                    for (i = 0; i < set_count; i++)
                        queue_result(ST_OK,
                                     set_keys[(r == REQ_LIST_ASC) ? i : set_count - 1 - i],
                                     i + 1 == set_count);
            default:
                ;
        endcase
    endtask

    // Offer one request at a falling edge, hold it until accepted
    task automatic offer_request(input req_t r, input key_t k, input logic typed,
                                 input status_t st, input key_t v);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        key      <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_request(r, k);
        if (typed)
        begin
            void'(pending_results.pop_back());
            queue_result(st, v, 1'b1);
        end
        if (r <= REQ_LIST_DESC)
            requests_sent++;
        else
            ignored_sent++;
        @(negedge clk);
    endtask

    // Favor keys that collide: a small pool, stored keys, extremes, then anything
    function automatic key_t pick_key(input bit prefer_stored);
        int roll;
        int v;
        roll = $urandom_range(99);
        if (set_count > 0 && (prefer_stored ? roll < 85 : roll < 15))
            return set_keys[$urandom_range(set_count - 1)];
        roll = $urandom_range(99);
        if (roll < 65)
        begin
            v = $urandom_range(40);
            return key_t'(v - 20);
        end
        if (roll < 80)
        begin
            case ($urandom_range(3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 32'sd1;
                default: return KEY_MAX - 32'sd1;
            endcase
        end
        return key_t'($urandom);
    endfunction

    function automatic req_t pick_request(input traffic_phase_t ph);
        int roll;
        roll = $urandom_range(99);
        case (ph)
            PH_FILL:
                if (roll < 76)      return REQ_INSERT;
                else if (roll < 84) return REQ_SEARCH;
                else if (roll < 88) return REQ_REMOVE;
                else if (roll < 94) return REQ_LIST_ASC;
                else                return REQ_LIST_DESC;
            PH_DRAIN:
                if (roll < 76)      return REQ_REMOVE;
                else if (roll < 84) return REQ_SEARCH;
                else if (roll < 88) return REQ_INSERT;
                else if (roll < 94) return REQ_LIST_ASC;
                else                return REQ_LIST_DESC;
            default:
                if (roll < 3)
                    return req_t'($urandom_range(REQ_RESERVED_HI, REQ_RESERVED_LO));
                else
                    return req_t'($urandom_range(REQ_LIST_DESC, REQ_SEARCH));
        endcase
    endfunction

    // Check each result against the oldest pending one
    always @(posedge clk)
    begin : check_result
        set_result_t head;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (status == ST_FULL)    full_seen++;
            if (status == ST_PRESENT) present_seen++;
            if (status == ST_EMPTY)   empty_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d value %0d last %0b",
                       status, value, is_last);
                mismatch_count++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (status !== head.status)
                begin
                    $error("status: expected %0d, got %0d", head.status, status);
                    mismatch_count++;
                end
                if (value !== head.value)
                begin
                    $error("value: expected %0d, got %0d", head.value, value);
                    mismatch_count++;
                end
                if (is_last !== head.is_last)
                begin
                    $error("is_last: expected %0b, got %0b", head.is_last, is_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Consumer: random stalls, one long hold-off to back up the block
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_checked >= 60)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Producer: reset, directed table, then phased random traffic
    initial
    begin
        traffic_phase_t phase;
        int   accepted_random;
        int   mix_left;
        int   full_mark;
        bit   paused;
        req_t r;
        key_t k;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_SEARCH;
        key      = 32'sd0;
        set_count = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (script[i])
            offer_request(script[i].req, script[i].key, script[i].typed,
                          script[i].status, script[i].value);

        // Start by filling the set so the full case is reached early
        phase = PH_FILL;
        full_mark = full_predicted;
        mix_left = 0;
        accepted_random = 0;
        paused = 1'b0;
        while (accepted_random < RANDOM_ITEMS)
        begin
            calm = (accepted_random >= 80) && (accepted_random < 140);

            // Let the pipe drain completely once mid-run
            if (!paused && accepted_random >= 180)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending_results.size() != 0)
                    @(negedge clk);
            end

            // Advance the traffic phase
            if (phase == PH_FILL && full_predicted - full_mark >= 3)
                phase = PH_DRAIN;
            else if (phase == PH_DRAIN && set_count == 0)
            begin
                phase = PH_MIX;
                mix_left = $urandom_range(40, 20);
            end
            else if (phase == PH_MIX && mix_left == 0)
            begin
                case ($urandom_range(2))
                    0: phase = PH_FILL;
                    1: phase = PH_DRAIN;
                    default: mix_left = $urandom_range(40, 20);
                endcase
                full_mark = full_predicted;
            end

            r = pick_request(phase);
            if (r == REQ_LIST_ASC || r == REQ_LIST_DESC || r > REQ_LIST_DESC)
                k = key_t'($urandom);
            else
                k = pick_key(phase == PH_DRAIN && r == REQ_REMOVE);
            offer_request(r, k, 1'b0, ST_OK, 32'sd0);
            if (r <= REQ_LIST_DESC)
            begin
                accepted_random++;
                if (phase == PH_MIX && mix_left > 0)
                    mix_left--;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Wait for the last results, then keep watching for strays
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests and %0d dropped codes, %0d results checked",
                 requests_sent, ignored_sent, results_checked);
        $display("Statuses seen: %0d full, %0d already present, %0d set empty",
                 full_seen, present_seen, empty_seen);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
